// ===== rtl/bwe_pkg.sv =====
// Shared types, constants and the sequencer microprogram for the bandwidth estimate block.
package bwe_pkg;

  localparam int unsigned NUM_W = 52;              // segs * seg * 1e6 fits in 52 bits
  localparam int unsigned ACC_W = 96;              // estimate * rtt, up to 64 + 32 bits
  localparam logic [31:0] US_PER_S = 32'd1000000;
  localparam logic [5:0]  CNT_SMP = 6'(NUM_W - 1); // one quotient bit per step
  localparam logic [5:0]  CNT_THR = 6'd31;

  typedef enum logic [1:0] {
    EV_ACK      = 2'd0,
    EV_TIMEOUT  = 2'd1,
    EV_RECOVERY = 2'd2,
    EV_QUERY    = 2'd3
  } ev_t;

  typedef enum logic [1:0] {
    REG_ALPHA    = 2'd0,
    REG_RECOVERY = 2'd1,
    REG_SEGMENT  = 2'd2
  } reg_idx_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_SMP_STORE,
    OP_EST_BLEND,
    OP_EST_SEED,
    OP_ACK_TAIL,
    OP_DIV_LOAD_SMP,
    OP_DIV_LOAD_THR,
    OP_DIV_STEP,
    OP_DIV_SET,
    OP_THR_FIN
  } dp_op_t;

  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_SEG_SEGS,
    MUL_PROD_US,
    MUL_EST_LO_W,
    MUL_EST_HI_W,
    MUL_SMP_LO_W2,
    MUL_SMP_HI_W2,
    MUL_US_A,
    MUL_EST_LO_RTT,
    MUL_EST_HI_RTT
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD_LO,
    ACC_ADD_HI
  } acc_op_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_REQ,
    C_NOT_ACK,
    C_NO_SAMPLE,
    C_EST_ZERO,
    C_NOT_USABLE,
    C_THR_OVER,
    C_CNT_NZ
  } cond_t;

  typedef logic [4:0] step_t;

  localparam step_t ST_IDLE     = 5'd0;
  localparam step_t ST_DISP     = 5'd1;
  localparam step_t ST_ACK      = 5'd2;
  localparam step_t ST_ACK_US   = 5'd3;
  localparam step_t ST_SDIV_LD  = 5'd4;
  localparam step_t ST_SDIV     = 5'd5;
  localparam step_t ST_SMP      = 5'd6;
  localparam step_t ST_BL_1     = 5'd7;
  localparam step_t ST_BL_2     = 5'd8;
  localparam step_t ST_BL_3     = 5'd9;
  localparam step_t ST_BL_4     = 5'd10;
  localparam step_t ST_BLEND    = 5'd11;
  localparam step_t ST_SEED     = 5'd12;
  localparam step_t ST_ACK_TAIL = 5'd13;
  localparam step_t ST_EMIT     = 5'd14;
  localparam step_t ST_CHK      = 5'd15;
  localparam step_t ST_DSET     = 5'd16;
  localparam step_t ST_TP_1     = 5'd17;
  localparam step_t ST_TP_2     = 5'd18;
  localparam step_t ST_TDIV_LD  = 5'd19;
  localparam step_t ST_TDIV     = 5'd20;
  localparam step_t ST_TFIN     = 5'd21;

  typedef struct packed {
    dp_op_t   op;
    mul_sel_t mul;
    acc_op_t  acc;
    cond_t    cond;
    step_t    target;
    logic     emit;
  } ctrl_t;

  typedef struct packed {
    logic not_ack;
    logic no_sample;
    logic est_zero;
    logic not_usable;
    logic thr_over;
    logic cnt_nz;
  } dp_status_t;

  function automatic ctrl_t cw(dp_op_t op, mul_sel_t mul, acc_op_t acc, cond_t cond,
                               step_t target, logic emit);
    ctrl_t w;
    w.op = op;
    w.mul = mul;
    w.acc = acc;
    w.cond = cond;
    w.target = target;
    w.emit = emit;
    return w;
  endfunction

  // Microprogram ROM. Fall through to step + 1 unless the condition holds.
  function automatic ctrl_t ucode(step_t s);
    ctrl_t w;
    unique case (s)
      ST_IDLE:     w = cw(OP_NONE, MUL_NONE, ACC_HOLD, C_NO_REQ, ST_IDLE, 1'b0);
      ST_DISP:     w = cw(OP_NONE, MUL_NONE, ACC_HOLD, C_NOT_ACK, ST_CHK, 1'b0);
      ST_ACK:      w = cw(OP_NONE, MUL_SEG_SEGS, ACC_HOLD, C_NO_SAMPLE, ST_ACK_TAIL, 1'b0);
      ST_ACK_US:   w = cw(OP_NONE, MUL_PROD_US, ACC_HOLD, C_NEVER, ST_IDLE, 1'b0);
      ST_SDIV_LD:  w = cw(OP_DIV_LOAD_SMP, MUL_NONE, ACC_HOLD, C_NEVER, ST_IDLE, 1'b0);
      ST_SDIV:     w = cw(OP_DIV_STEP, MUL_NONE, ACC_HOLD, C_CNT_NZ, ST_SDIV, 1'b0);
      ST_SMP:      w = cw(OP_SMP_STORE, MUL_EST_LO_W, ACC_HOLD, C_EST_ZERO, ST_SEED, 1'b0);
      ST_BL_1:     w = cw(OP_NONE, MUL_EST_HI_W, ACC_LOAD, C_NEVER, ST_IDLE, 1'b0);
      ST_BL_2:     w = cw(OP_NONE, MUL_SMP_LO_W2, ACC_ADD_HI, C_NEVER, ST_IDLE, 1'b0);
      ST_BL_3:     w = cw(OP_NONE, MUL_SMP_HI_W2, ACC_ADD_LO, C_NEVER, ST_IDLE, 1'b0);
      ST_BL_4:     w = cw(OP_NONE, MUL_NONE, ACC_ADD_HI, C_NEVER, ST_IDLE, 1'b0);
      ST_BLEND:    w = cw(OP_EST_BLEND, MUL_NONE, ACC_HOLD, C_ALWAYS, ST_ACK_TAIL, 1'b0);
      ST_SEED:     w = cw(OP_EST_SEED, MUL_NONE, ACC_HOLD, C_NEVER, ST_IDLE, 1'b0);
      ST_ACK_TAIL: w = cw(OP_ACK_TAIL, MUL_NONE, ACC_HOLD, C_NEVER, ST_IDLE, 1'b0);
      ST_EMIT:     w = cw(OP_NONE, MUL_NONE, ACC_HOLD, C_ALWAYS, ST_IDLE, 1'b1);
      ST_CHK:      w = cw(OP_NONE, MUL_US_A, ACC_HOLD, C_NOT_USABLE, ST_EMIT, 1'b0);
      ST_DSET:     w = cw(OP_DIV_SET, MUL_EST_LO_RTT, ACC_HOLD, C_NEVER, ST_IDLE, 1'b0);
      ST_TP_1:     w = cw(OP_NONE, MUL_EST_HI_RTT, ACC_LOAD, C_NEVER, ST_IDLE, 1'b0);
      ST_TP_2:     w = cw(OP_NONE, MUL_NONE, ACC_ADD_HI, C_NEVER, ST_IDLE, 1'b0);
      ST_TDIV_LD:  w = cw(OP_DIV_LOAD_THR, MUL_NONE, ACC_HOLD, C_THR_OVER, ST_TFIN, 1'b0);
      ST_TDIV:     w = cw(OP_DIV_STEP, MUL_NONE, ACC_HOLD, C_CNT_NZ, ST_TDIV, 1'b0);
      ST_TFIN:     w = cw(OP_THR_FIN, MUL_NONE, ACC_HOLD, C_ALWAYS, ST_EMIT, 1'b0);
      default:     w = cw(OP_NONE, MUL_NONE, ACC_HOLD, C_ALWAYS, ST_IDLE, 1'b0);
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/bwe_datapath.sv =====
// Datapath: event registers, estimator state, shared multiplier, accumulator and divider.
module bwe_datapath import bwe_pkg::*; #(
  parameter int unsigned BWE_WIDTH = 40
) (
  input  logic        clk,
  input  logic        rst,
  input  ctrl_t       ctrl,
  input  logic        capture,
  input  ev_t         op,
  input  logic [31:0] now_us,
  input  logic [15:0] segments_acked,
  input  logic [31:0] rtt_us,
  input  logic [31:0] bytes_in_flight,
  input  logic [8:0]  alpha_q8,
  input  logic [7:0]  recovery_factor,
  input  logic [15:0] segment_size,
  output dp_status_t  status,
  output logic [31:0] new_ssthresh,
  output logic        ssthresh_valid,
  output logic [31:0] new_cwnd,
  output logic        cwnd_valid
);

  localparam logic [63:0] BWE_MAX = {64{1'b1}} >> (64 - BWE_WIDTH);

  // captured event
  ev_t         op_r;
  logic [31:0] now_r;
  logic [15:0] segs_r;
  logic [31:0] rtt_r;
  logic [31:0] bif_r;

  // estimator state
  logic                 first_ack_pending;
  logic [31:0]          last_ack_time;
  logic [BWE_WIDTH-1:0] bandwidth_estimate;
  logic [31:0]          min_rtt;
  logic                 min_rtt_seen;

  // working registers
  logic [63:0]          prod;
  logic [ACC_W-1:0]     acc, acc_next;
  logic [31:0]          rem, rem_next;
  logic [31:0]          divisor;
  logic [5:0]           cnt, cnt_next;
  logic                 sat;
  logic [BWE_WIDTH-1:0] smp;
  logic [31:0]          thr;

  logic [31:0]  mul_a, mul_b;
  logic [63:0]  est64, smp64, q64;
  logic [8:0]   w, w2;
  logic [7:0]   a_eff;
  logic [31:0]  delta, floor2, half, t_raw;
  logic [32:0]  r2, r2_sub;
  logic         ge, usable, thr_over;

  assign est64  = 64'(bandwidth_estimate);
  assign smp64  = 64'(smp);
  assign w      = (alpha_q8 > 9'd256) ? 9'd256 : alpha_q8;
  assign w2     = 9'(9'd256 - w);
  assign a_eff  = (recovery_factor == 8'd0) ? 8'd1 : recovery_factor;
  assign delta  = now_r - last_ack_time;
  assign floor2 = 32'({segment_size, 1'b0});
  assign half   = {1'b0, bif_r[31:1]};
  assign usable = (bandwidth_estimate != '0) && min_rtt_seen;
  assign q64    = 64'(acc[NUM_W-1:0]);
  assign thr_over = acc[ACC_W-1:32] >= 64'(divisor);

  // one restoring division step: quotient bit enters acc from the bottom
  assign r2     = {rem, acc[ACC_W-1]};
  assign r2_sub = r2 - {1'b0, divisor};
  assign ge     = r2 >= {1'b0, divisor};

  assign status.not_ack    = (op_r != EV_ACK);
  assign status.no_sample  = first_ack_pending || (segs_r == 16'd0) || (delta == 32'd0);
  assign status.est_zero   = (bandwidth_estimate == '0);
  assign status.not_usable = !usable;
  assign status.thr_over   = thr_over;
  assign status.cnt_nz     = (cnt != 6'd0);

  always_comb begin
    unique case (ctrl.mul)
      MUL_SEG_SEGS:   begin mul_a = 32'(segment_size); mul_b = 32'(segs_r); end
      MUL_PROD_US:    begin mul_a = prod[31:0];        mul_b = US_PER_S;    end
      MUL_EST_LO_W:   begin mul_a = est64[31:0];       mul_b = 32'(w);      end
      MUL_EST_HI_W:   begin mul_a = est64[63:32];      mul_b = 32'(w);      end
      MUL_SMP_LO_W2:  begin mul_a = smp64[31:0];       mul_b = 32'(w2);     end
      MUL_SMP_HI_W2:  begin mul_a = smp64[63:32];      mul_b = 32'(w2);     end
      MUL_US_A:       begin mul_a = US_PER_S;          mul_b = 32'(a_eff);  end
      MUL_EST_LO_RTT: begin mul_a = est64[31:0];       mul_b = min_rtt;     end
      MUL_EST_HI_RTT: begin mul_a = est64[63:32];      mul_b = min_rtt;     end
      default:        begin mul_a = prod[31:0];        mul_b = 32'd0;       end
    endcase
  end

  always_comb begin
    acc_next = acc;
    rem_next = rem;
    cnt_next = cnt;
    case (ctrl.acc)
      ACC_LOAD:   acc_next = ACC_W'(prod);
      ACC_ADD_LO: acc_next = acc + ACC_W'(prod);
      ACC_ADD_HI: acc_next = acc + {prod, 32'd0};
      default:    acc_next = acc;
    endcase
    case (ctrl.op)
      OP_DIV_LOAD_SMP: begin
        acc_next = {prod[NUM_W-1:0], (ACC_W - NUM_W)'(0)};
        rem_next = 32'd0;
        cnt_next = CNT_SMP;
      end
      OP_DIV_LOAD_THR: begin
        acc_next = {acc[31:0], 64'd0};
        rem_next = acc[63:32];
        cnt_next = CNT_THR;
      end
      OP_DIV_STEP: begin
        acc_next = {acc[ACC_W-2:0], ge};
        rem_next = ge ? r2_sub[31:0] : r2[31:0];
        cnt_next = cnt - 6'd1;
      end
      default: ;
    endcase
  end

  always_comb begin
    t_raw = sat ? 32'hFFFF_FFFF : acc[31:0];
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      op_r   <= op;
      now_r  <= now_us;
      segs_r <= segments_acked;
      rtt_r  <= rtt_us;
      bif_r  <= bytes_in_flight;
    end
    if (ctrl.mul != MUL_NONE) prod <= mul_a * mul_b;
    acc <= acc_next;
    rem <= rem_next;
    cnt <= cnt_next;
    case (ctrl.op)
      OP_SMP_STORE:
        smp <= (q64 > BWE_MAX) ? BWE_MAX[BWE_WIDTH-1:0] : q64[BWE_WIDTH-1:0];
      OP_DIV_LOAD_SMP: divisor <= delta;
      OP_DIV_SET:      divisor <= prod[31:0];
      OP_DIV_LOAD_THR: sat <= thr_over;
      OP_THR_FIN:      thr <= (t_raw > floor2) ? t_raw : floor2;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_ack_pending  <= 1'b1;
      last_ack_time      <= 32'd0;
      bandwidth_estimate <= '0;
      min_rtt            <= 32'hFFFF_FFFF;
      min_rtt_seen       <= 1'b0;
    end else begin
      case (ctrl.op)
        OP_EST_SEED:  bandwidth_estimate <= smp;
        // blend sum never exceeds the larger operand, so no clamp is needed
        OP_EST_BLEND: bandwidth_estimate <= acc[BWE_WIDTH+7:8];
        OP_ACK_TAIL: begin
          first_ack_pending <= 1'b0;
          last_ack_time     <= now_r;
          if ((rtt_r != 32'd0) && (!min_rtt_seen || (rtt_r < min_rtt))) begin
            min_rtt      <= rtt_r;
            min_rtt_seen <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // result formatting
  always_comb begin
    new_ssthresh   = 32'd0;
    ssthresh_valid = 1'b0;
    new_cwnd       = 32'd0;
    cwnd_valid     = 1'b0;
    unique case (op_r)
      EV_TIMEOUT: begin
        if (usable) begin
          new_ssthresh   = thr;
          ssthresh_valid = 1'b1;
        end
        new_cwnd   = 32'(segment_size);
        cwnd_valid = 1'b1;
      end
      EV_RECOVERY: begin
        if (usable) begin
          new_ssthresh   = thr;
          ssthresh_valid = 1'b1;
          new_cwnd       = thr;
          cwnd_valid     = 1'b1;
        end
      end
      EV_QUERY: begin
        if (usable) new_ssthresh = thr;
        else        new_ssthresh = (half > floor2) ? half : floor2;
        ssthresh_valid = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/bandwidth_estimate_ssthresh.sv =====
// Top level: microcoded sequencer, configuration registers and output register.
//
// Bandwidth-estimate slow start threshold engine. Each request on the input
// stream is one event (op in tuser: ack, timeout loss, fast recovery, query);
// each event yields exactly one result request on the output stream. One event
// is processed at a time: s_axis_tready is high only while the sequencer sits
// in its idle step. An ack that produces a bandwidth sample runs the 52-step
// bit-serial divide of bytes*1e6 by elapsed time, then a four-product blend
// through the single 32x32 multiplier, or seeds the estimate when it is zero.
// Loss, recovery and query events with a usable estimate run the 32-step
// divide by 1e6 * recovery_factor, skipped when the threshold saturates.
// Events without a usable estimate and acks with no sample skip these steps.
// The emit step waits while the output register is full and not draining. A
// finished result sits in the output register, so the next event is accepted
// while the previous result still waits to be taken. Configuration writes are
// registered and must only be issued while the engine is idle.
module bandwidth_estimate_ssthresh import bwe_pkg::*; #(
  parameter int unsigned BWE_WIDTH = 40
) (
  input  logic         clk,
  input  logic         rst,
  // input event stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [111:0] s_axis_tdata,   // now_us, segments_acked, rtt_us, bytes_in_flight
  input  logic [1:0]   s_axis_tuser,   // op
  // result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata,   // new_ssthresh, new_cwnd
  output logic [1:0]   m_axis_tuser,   // ssthresh_valid, cwnd_valid
  // configuration writes
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  step_t       upc, upc_next;
  ctrl_t       ctrl;
  dp_status_t  status;
  logic        s_accept;
  logic        take;
  logic        hold;
  logic        out_load;

  logic [8:0]  alpha_q8;
  logic [7:0]  recovery_factor;
  logic [15:0] segment_size;

  logic [31:0] res_ss, res_cw;
  logic        res_ssv, res_cwv;

  // control word of the current step
  assign ctrl          = ucode(upc);
  assign s_axis_tready = (upc == ST_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // emit step stalls only when the output register is full and not draining
  assign hold     = ctrl.emit && m_axis_tvalid && !m_axis_tready;
  assign out_load = ctrl.emit && !hold;

  always_comb begin
    unique case (ctrl.cond)
      C_NEVER:      take = 1'b0;
      C_ALWAYS:     take = 1'b1;
      C_NO_REQ:     take = !s_accept;
      C_NOT_ACK:    take = status.not_ack;
      C_NO_SAMPLE:  take = status.no_sample;
      C_EST_ZERO:   take = status.est_zero;
      C_NOT_USABLE: take = status.not_usable;
      C_THR_OVER:   take = status.thr_over;
      C_CNT_NZ:     take = status.cnt_nz;
      default:      take = 1'b0;
    endcase
    if (hold)      upc_next = upc;
    else if (take) upc_next = ctrl.target;
    else           upc_next = step_t'(upc + 5'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) upc <= ST_IDLE;
    else     upc <= upc_next;
  end

  // configuration registers; an index past the list is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_q8        <= 9'd205;
      recovery_factor <= 8'd1;
      segment_size    <= 16'd536;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_ALPHA:    alpha_q8        <= cfg_data[8:0];
        REG_RECOVERY: recovery_factor <= cfg_data[7:0];
        REG_SEGMENT:  segment_size    <= cfg_data;
        default: ;
      endcase
    end
  end

  bwe_datapath #(
    .BWE_WIDTH(BWE_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .ctrl            (ctrl),
    .capture         (s_accept),
    .op              (ev_t'(s_axis_tuser)),
    .now_us          (s_axis_tdata[31:0]),
    .segments_acked  (s_axis_tdata[47:32]),
    .rtt_us          (s_axis_tdata[79:48]),
    .bytes_in_flight (s_axis_tdata[111:80]),
    .alpha_q8        (alpha_q8),
    .recovery_factor (recovery_factor),
    .segment_size    (segment_size),
    .status          (status),
    .new_ssthresh    (res_ss),
    .ssthresh_valid  (res_ssv),
    .new_cwnd        (res_cw),
    .cwnd_valid      (res_cwv)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst)               m_axis_tvalid <= 1'b0;
    else if (out_load)     m_axis_tvalid <= 1'b1;
    else if (m_axis_tready) m_axis_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {res_cw, res_ss};
      m_axis_tuser <= {res_cwv, res_ssv};
    end
  end

endmodule

// ===== rtl/bwe_checker.sv =====
// Port-level checker for the bandwidth estimate block, bound to the top level.
module bwe_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [63:0]  m_axis_tdata,
  input logic [1:0]   m_axis_tuser
);

  // one event in flight: no request taken right after another
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken back to back");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("result changed while stalled");

  // fields without their valid flag read as zero
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      ((m_axis_tuser[0] || (m_axis_tdata[31:0] == 32'd0)) &&
       (m_axis_tuser[1] || (m_axis_tdata[63:32] == 32'd0))))
    else $error("unflagged result field not zero");

  // reset leaves the engine idle with no result pending
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (s_axis_tready && !m_axis_tvalid))
    else $error("not idle after reset");

endmodule

bind bandwidth_estimate_ssthresh bwe_checker u_bwe_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
